// ===== rtl/core/prq_pkg.sv =====
// prq_pkg: shared types and codes for the sorted priority ring queue
// no dependencies
package prq_pkg;

    localparam int PRIO_W = 2;
    localparam int TAG_W  = 16;
    localparam int STAT_W = 2;

    // request codes
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_PUSHED = 2'd0;
    localparam logic [STAT_W-1:0] ST_POPPED = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic take_req;   // latch incoming word, start insert pointer at tail
        logic rd_head;    // read slot at head
        logic rd_prev;    // read slot below insert pointer
        logic shift;      // move read entry up into insert slot, step pointer down
        logic insert;     // write new entry at insert pointer
        logic load_res;   // commit pointers and flags, load result word
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_pop;
        logic full;
        logic empty;
        logic k_at_head;  // insert pointer sits at head
        logic ra_at_head; // last read slot is the head slot
        logic rd_greater; // read entry has a larger priority value than the new one
        logic out_free;   // output register can take a word
    } t_stat;

endpackage

// ===== rtl/core/prq_if.sv =====
// prq_in_if / prq_out_if: valid/ready channels for request and result words
// depends on prq_pkg
interface prq_in_if
    import prq_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [PRIO_W-1:0] priority_req;
    logic [TAG_W-1:0]  payload;

    modport source (output valid, output req_type, output priority_req, output payload,
                    input ready);
    modport sink   (input valid, input req_type, input priority_req, input payload,
                    output ready);
endinterface

interface prq_out_if
    import prq_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [PRIO_W-1:0] out_priority;
    logic [TAG_W-1:0]  out_payload;

    modport source (output valid, output status, output out_priority, output out_payload,
                    input ready);
    modport sink   (input valid, input status, input out_priority, input out_payload,
                    output ready);
endinterface

// ===== rtl/core/priority_ring_queue_top.sv =====
// priority_ring_queue_top: sorted priority queue in a ring of DEPTH slots
// pop, refused push, push into an empty ring: DECIDE, then the result word is loaded in RES
// other pushes: DECIDE, then the insert walk in SHIFT (and INS once it reaches the head), then RES;
//   the insert walk moves entries toward the tail over the slot memory at one slot per cycle
// one request in flight; the next is taken the cycle after the result is loaded,
//   which waits while the result register is held; reset empties the queue and clears the result valid
module priority_ring_queue_top
    import prq_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    prq_in_if.sink      i_req,
    prq_out_if.source   o_res
);

    t_cmd  cmd;
    t_stat stat;

    prq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    prq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_req_type     (i_req.req_type),
        .i_priority_req (i_req.priority_req),
        .i_payload      (i_req.payload),
        .i_out_ready    (o_res.ready),
        .o_out_valid    (o_res.valid),
        .o_status       (o_res.status),
        .o_out_priority (o_res.out_priority),
        .o_out_payload  (o_res.out_payload)
    );

endmodule

// ===== rtl/core/prq_dp.sv =====
// prq_dp: slot memory, head/tail pointers, flags, insert walk pointer, result register
// depends on prq_pkg
module prq_dp
    import prq_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic              i_req_type,
    input  logic [PRIO_W-1:0] i_priority_req,
    input  logic [TAG_W-1:0]  i_payload,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [STAT_W-1:0] o_status,
    output logic [PRIO_W-1:0] o_out_priority,
    output logic [TAG_W-1:0]  o_out_payload
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] p);
        return (p == LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] f_prev(input logic [AW-1:0] p);
        return (p == '0) ? LAST : p - 1'b1;
    endfunction

    t_entry mem [DEPTH];

    logic [AW-1:0]     r_head;
    logic [AW-1:0]     r_tail;
    logic              r_full;
    logic              r_empty;
    logic [AW-1:0]     r_k;
    logic [AW-1:0]     r_ra;
    t_entry            r_rd;
    logic              r_op;
    logic [PRIO_W-1:0] r_prio;
    logic [TAG_W-1:0]  r_tag;
    logic              r_out_valid;
    logic [STAT_W-1:0] r_status;
    logic [PRIO_W-1:0] r_oprio;
    logic [TAG_W-1:0]  r_opay;

    logic [AW-1:0] n_ra;
    logic          n_re;
    logic          n_we;
    t_entry        n_wd;
    logic [AW-1:0] n_tail;
    logic [AW-1:0] n_head;
    logic          n_push_ok;
    logic          n_pop_ok;

    always_comb begin
        n_re = i_cmd.rd_head | i_cmd.rd_prev;
        if (i_cmd.rd_head) begin
            n_ra = r_head;
        end else begin
            // after a shift the insert pointer moves to the slot just read
            n_ra = f_prev(i_cmd.shift ? r_ra : r_k);
        end
        n_we = i_cmd.shift | i_cmd.insert;
        n_wd = i_cmd.shift ? r_rd : t_entry'{prio: r_prio, tag: r_tag};
    end

    // slot memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (n_we) begin
            mem[r_k] <= n_wd;
        end
        if (n_re) begin
            r_rd <= mem[n_ra];
            r_ra <= n_ra;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_req) begin
            r_op   <= i_req_type;
            r_prio <= i_priority_req;
            r_tag  <= i_payload;
            r_k    <= r_tail;
        end else if (i_cmd.shift) begin
            r_k <= r_ra;
        end
    end

    assign n_tail    = f_next(r_tail);
    assign n_head    = f_next(r_head);
    assign n_push_ok = (r_op == REQ_PUSH) && !r_full;
    assign n_pop_ok  = (r_op == REQ_POP) && !r_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_full      <= 1'b0;
            r_empty     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_res) begin
                r_out_valid <= 1'b1;
                if (n_push_ok) begin
                    r_tail  <= n_tail;
                    r_empty <= 1'b0;
                    r_full  <= (n_tail == r_head);
                end else if (n_pop_ok) begin
                    r_head  <= n_head;
                    r_full  <= 1'b0;
                    r_empty <= (n_head == r_tail);
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_res) begin
            if (r_op == REQ_PUSH) begin
                r_status <= r_full ? ST_FULL : ST_PUSHED;
            end else begin
                r_status <= r_empty ? ST_EMPTY : ST_POPPED;
            end
            r_oprio <= n_pop_ok ? r_rd.prio : '0;
            r_opay  <= n_pop_ok ? r_rd.tag : '0;
        end
    end

    assign o_stat.is_pop     = (r_op == REQ_POP);
    assign o_stat.full       = r_full;
    assign o_stat.empty      = r_empty;
    assign o_stat.k_at_head  = (r_k == r_head);
    assign o_stat.ra_at_head = (r_ra == r_head);
    assign o_stat.rd_greater = (r_rd.prio > r_prio);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_out_priority = r_oprio;
    assign o_out_payload  = r_opay;

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_full && r_empty))
        else $error("queue flagged full and empty together");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty |-> (r_head == r_tail))
        else $error("empty queue with head and tail apart");

    a_full_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (r_head == r_tail))
        else $error("full queue with head and tail apart");

endmodule

// ===== rtl/core/prq_ctrl.sv =====
// prq_ctrl: sequencer for push insert walk, pop read and result hand-off
// depends on prq_pkg
module prq_ctrl
    import prq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_INS    = 3'd3;
    localparam logic [2:0] S_RES    = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // no word is taken while reset is held
                o_in_ready     = i_rst_n;
                o_cmd.take_req = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.is_pop) begin
                    o_cmd.rd_head = !i_stat.empty;
                    n_state       = S_RES;
                end else if (i_stat.full) begin
                    n_state = S_RES;
                end else if (i_stat.k_at_head) begin
                    o_cmd.insert = 1'b1;
                    n_state      = S_RES;
                end else begin
                    o_cmd.rd_prev = 1'b1;
                    n_state       = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (i_stat.rd_greater) begin
                    o_cmd.shift = 1'b1;
                    if (i_stat.ra_at_head) begin
                        n_state = S_INS;
                    end else begin
                        o_cmd.rd_prev = 1'b1;
                    end
                end else begin
                    o_cmd.insert = 1'b1;
                    n_state      = S_RES;
                end
            end
            S_INS: begin
                o_cmd.insert = 1'b1;
                n_state      = S_RES;
            end
            S_RES: begin
                if (i_stat.out_free) begin
                    o_cmd.load_res = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
